[rtl/breakpoint_segment_locate_defines.svh]
// Assertion macros for the breakpoint segment locator.
// Needs clk and arst_n in the scope where a macro is used; no other dependencies.
`ifndef BREAKPOINT_SEGMENT_LOCATE_DEFINES_SVH
`define BREAKPOINT_SEGMENT_LOCATE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define BSL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled while in reset
`define BSL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BSL_ASSERT_IMP(lbl, ante, cons, msg)
`define BSL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/bsl_pkg.sv]
// Shared constants for the breakpoint segment locator.
// No dependencies.
`default_nettype none

package bsl_pkg;

	// fixed field widths
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;

	// segment count after reset
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

	// operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

[rtl/breakpoint_segment_locate.sv]
// Breakpoint segment locator: bound table plus bisection search over it.
// Depends on bsl_pkg and breakpoint_segment_locate_defines.svh.
//
//   channel   signals                                  direction
//   in        in_valid/in_ready, op, entry_index, value  beat in
//   out       out_valid/out_ready, segment_index         beat out
//   cfg       cfg_wr_en, cfg_wr_data                     write only
//
// A load beat is written into the table at acceptance.
// A query beat holds the input from acceptance through the S_STEP bisection
// steps, S_FIRST, S_LAST (skipped when x equals the first bound) and S_DONE,
// the bisection steps numbering floor or ceil of log2 of the segment count, 10
// at 1024 segments; the single table read port and the one compare unit give
// one bisection step per cycle.
// Reset leaves the table contents undefined and the segment count at 1.
// A finished result waits in the output register while the next beat is taken;
// a further query stalls in its last cycle until that register is free.
`default_nettype none
`include "breakpoint_segment_locate_defines.svh"

module breakpoint_segment_locate
	import bsl_pkg::*;
#(
	parameter int MAX_SEGMENTS = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      op,
	input  wire logic [INDEX_W-1:0]        entry_index,
	input  wire logic signed [VALUE_W-1:0] value,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [INDEX_W-1:0]             segment_index,
	input  wire logic                      cfg_wr_en,
	input  wire logic [COUNT_W-1:0]        cfg_wr_data
);

	localparam int AW    = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_FIRST,
		S_LAST,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   count_q;
	logic [VALUE_W-1:0]   x_q;
	logic [CNT_W-1:0]     lo_q;
	logic [CNT_W-1:0]     hi_q;
	logic [CNT_W-1:0]     mid_q;
	logic [CNT_W-1:0]     res_q;
	logic                 out_valid_q;
	logic [INDEX_W-1:0]   seg_q;
	logic                 out_load;

	logic [VALUE_W-1:0]   mem [MAX_SEGMENTS];
	logic [VALUE_W-1:0]   rd_data_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic                 slot_ok;

	logic [CMP_W-1:0]     count_ext;
	logic [CNT_W-1:0]     n_eff;
	logic [CNT_W-1:0]     n_last;
	logic [VALUE_W:0]     diff;
	logic                 ge;
	logic                 eq;
	logic [CNT_W:0]       sum_up;
	logic [CNT_W:0]       sum_dn;
	logic [CNT_W-1:0]     mid_up;
	logic [CNT_W-1:0]     mid_dn;
	logic                 more_up;
	logic                 more_dn;
	logic [CNT_W-1:0]     mid_next;
	logic                 step_more;

	// clamp the programmed count to 1..MAX_SEGMENTS
	always_comb begin
		count_ext = CMP_W'(count_q);
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_ext > CMP_W'(MAX_SEGMENTS)) begin
			n_eff = CNT_W'(MAX_SEGMENTS);
		end else begin
			n_eff = CNT_W'(count_ext);
		end
		n_last = n_eff - CNT_W'(1);
	end

	// shared compare unit: signed x against the bound just read
	always_comb begin
		diff = {x_q[VALUE_W-1], x_q} - {rd_data_q[VALUE_W-1], rd_data_q};
		ge   = ~diff[VALUE_W];
		eq   = (diff == '0);
	end

	// both candidate midpoints, picked once the compare settles
	always_comb begin
		sum_up    = {1'b0, mid_q} + {1'b0, hi_q};
		sum_dn    = {1'b0, lo_q} + {1'b0, mid_q};
		mid_up    = CNT_W'(sum_up >> 1);
		mid_dn    = CNT_W'(sum_dn >> 1);
		more_up   = (hi_q - mid_q) > CNT_W'(1);
		more_dn   = (mid_q - lo_q) > CNT_W'(1);
		mid_next  = ge ? mid_up : mid_dn;
		step_more = ge ? more_up : more_dn;
	end

	// table read address for the next cycle
	always_comb begin
		case (state_q)
			S_IDLE: begin
				rd_addr = (n_eff > CNT_W'(1)) ? AW'(n_eff >> 1) : '0;
			end
			S_STEP: begin
				rd_addr = step_more ? AW'(mid_next) : '0;
			end
			S_FIRST: begin
				rd_addr = AW'(n_last);
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// drop loads aimed beyond the table
	assign slot_ok = CMP_W'(entry_index) < CMP_W'(MAX_SEGMENTS);
	assign wr_en   = (state_q == S_IDLE) && in_valid && (op == OP_LOAD) && slot_ok;

	// hand the finished index to the output register once it is free
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// bound table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(entry_index)] <= value;
		end
		rd_data_q <= mem[rd_addr];
	end

	// sequencer, search registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= COUNT_RESET;
			x_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			seg_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			// load the output register, or drop the beat once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				seg_q       <= INDEX_W'(res_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && (op == OP_QUERY)) begin
						x_q     <= value;
						lo_q    <= '0;
						hi_q    <= n_eff;
						mid_q   <= n_eff >> 1;
						state_q <= (n_eff > CNT_W'(1)) ? S_STEP : S_FIRST;
					end
				end
				S_STEP: begin
					if (ge) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q;
					end
					mid_q   <= mid_next;
					state_q <= step_more ? S_STEP : S_FIRST;
				end
				S_FIRST: begin
					if (eq) begin
						res_q   <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					res_q   <= eq ? n_last : lo_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign segment_index = seg_q;

	// checks
	`BSL_ASSERT_IMP(a_bracket, state_q == S_STEP, (hi_q > mid_q) && (mid_q > lo_q), "bisection bracket collapsed")
	`BSL_ASSERT_IMP(a_result_range, state_q == S_DONE, res_q < n_eff, "segment index beyond count")
	`BSL_ASSERT_NXT(a_query_busy, in_valid && in_ready && (op == OP_QUERY), !in_ready, "query did not stall input")
	`BSL_ASSERT_NXT(a_load_silent, in_valid && in_ready && (op == OP_LOAD) && !out_valid_q, !out_valid_q, "load raised a result")

endmodule

`default_nettype wire

[test/segment_check_pkg.sv]
// Scoreboard for the breakpoint segment locator testbench: bound table shadow,
// bisection predictor and the queue of expected segment indexes.
// Depends on bsl_pkg.
`timescale 1ns / 1ps

package segment_check_pkg;
	import bsl_pkg::*;

	localparam int TABLE_DEPTH  = 1024;
	localparam int REPORT_LIMIT = 10;

	class segment_checker;
		logic signed [VALUE_W-1:0] bound_table [TABLE_DEPTH];
		logic [COUNT_W-1:0]        count_reg;
		logic [INDEX_W-1:0]        expected_segments [$];
		int                        failures;
		int                        checked;
		int                        loads;
		int                        queries;

		function new();
			count_reg = COUNT_RESET;
			failures  = 0;
			checked   = 0;
			loads     = 0;
			queries   = 0;
			foreach (bound_table[i])
				bound_table[i] = '0;
		endfunction

		function void write_count(logic [COUNT_W-1:0] v);
			count_reg = v;
		endfunction

		// zero behaves as one segment, anything above the table saturates
		function int active_segments();
			int n;
			n = int'(count_reg);
			if (n == 0)
				n = 1;
			if (n > TABLE_DEPTH)
				n = TABLE_DEPTH;
			return n;
		endfunction

		// bisection over the active bounds, then the first/last equality overrides
		function logic [INDEX_W-1:0] locate_segment(logic signed [VALUE_W-1:0] x);
			int                 n;
			int                 lo;
			int                 hi;
			int                 mid;
			logic [INDEX_W-1:0] seg;
			n  = active_segments();
			lo = 0;
			hi = n;
			while (hi - lo > 1) begin
				mid = (lo + hi) >> 1;
				if (x >= bound_table[mid])
					lo = mid;
				else
					hi = mid;
			end
			if (x == bound_table[0])
				seg = '0;
			else if (x == bound_table[n-1])
				seg = INDEX_W'(n - 1);
			else
				seg = INDEX_W'(lo);
			return seg;
		endfunction

		// note an accepted input beat: store a bound or queue the expected index
		function void note_input(logic op_bit, logic [INDEX_W-1:0] slot,
				logic signed [VALUE_W-1:0] v);
			if (op_bit == OP_LOAD) begin
				loads++;
				if (int'(slot) < TABLE_DEPTH)
					bound_table[slot] = v;
			end else begin
				queries++;
				expected_segments.push_back(locate_segment(v));
			end
		endfunction

		function void report(string what);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("MISMATCH: %s", what);
		endfunction

		// compare an accepted result beat with the oldest expectation
		function void check_result(logic [INDEX_W-1:0] got);
			logic [INDEX_W-1:0] want;
			checked++;
			if (expected_segments.size() == 0) begin
				report($sformatf("segment_index %0d arrived with no query outstanding", got));
				return;
			end
			want = expected_segments.pop_front();
			if (got !== want)
				report($sformatf("segment_index expected %0d, got %0d", want, got));
		endfunction

		function int outstanding();
			return expected_segments.size();
		endfunction

		function void finish_check();
			if (expected_segments.size() != 0)
				report($sformatf("%0d expected results never arrived",
					expected_segments.size()));
		endfunction
	endclass

endpackage

[test/breakpoint_segment_locate_test.sv]
// Testbench top for the breakpoint segment locator: directed and random loads
// and queries under random flow control, checked against segment_check_pkg.
// Depends on bsl_pkg, segment_check_pkg and the breakpoint_segment_locate RTL.
`timescale 1ns / 1ps

module breakpoint_segment_locate_test;
	import bsl_pkg::*;
	import segment_check_pkg::*;

	localparam int ITEM_TARGET   = 1900;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 1000000;

	localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      op;
	logic [INDEX_W-1:0]        entry_index;
	logic signed [VALUE_W-1:0] value;
	logic                      out_valid;
	logic                      out_ready;
	logic [INDEX_W-1:0]        segment_index;
	logic                      cfg_wr_en;
	logic [COUNT_W-1:0]        cfg_wr_data;

	segment_checker board;
	bit             loaded [TABLE_DEPTH];
	int             items_sent     = 0;
	int             count_writes   = 0;
	int             send_idle_pct  = 27;
	int             recv_idle_pct  = 81;
	bit             hold_req       = 1'b0;

	breakpoint_segment_locate dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.entry_index   (entry_index),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.segment_index (segment_index),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// abort a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// receiver: random back-pressure, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// check every result beat
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(segment_index);
	end

	// offer one beat, with random gaps, and hold it until accepted
	task automatic send_beat(logic op_bit, logic [INDEX_W-1:0] slot,
			logic signed [VALUE_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		op          <= op_bit;
		entry_index <= slot;
		value       <= v;
		do @(posedge clk); while (!in_ready);
		board.note_input(op_bit, slot, v);
		if (op_bit == OP_LOAD)
			loaded[slot] = 1'b1;
		items_sent++;
		// advance the idling pattern by thirds of the run
		if (items_sent < ITEM_TARGET / 3) begin
			send_idle_pct = 27;
			recv_idle_pct = 81;
		end else if (items_sent < 2 * ITEM_TARGET / 3) begin
			send_idle_pct = 81;
			recv_idle_pct = 27;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	// drop valid and wait until every expected result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [COUNT_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		board.write_count(v);
		count_writes++;
	endtask

	// load an ascending table into slots 0..m-1, skipping written slots unless told
	task automatic load_ascending(int m, bit every_slot);
		int unsigned               cap;
		longint                    level;
		logic signed [VALUE_W-1:0] vals [];
		bit                        descending;
		int                        slot;
		cap   = 32'(64'h1_0000_0000 / (m + 1)) - 1;
		vals  = new[m];
		level = -64'sd2147483648 + longint'($urandom_range(0, cap));
		for (int i = 0; i < m; i++) begin
			if (i > 0 && $urandom_range(0, 99) >= 15)
				level += longint'($urandom_range(0, cap));
			vals[i] = VALUE_W'(level);
		end
		if ($urandom_range(0, 99) < 25) begin
			vals[0]   = Q_MIN;
			vals[m-1] = Q_MAX;
		end
		descending = $urandom_range(0, 1);
		for (int k = 0; k < m; k++) begin
			slot = descending ? m - 1 - k : k;
			if (every_slot || !loaded[slot])
				send_beat(OP_LOAD, INDEX_W'(slot), vals[slot]);
		end
	endtask

	// query point: hit a bound, land next to one, an extreme, or anywhere
	function automatic logic signed [VALUE_W-1:0] pick_query(int m);
		int                        r;
		logic signed [VALUE_W-1:0] b;
		r = $urandom_range(0, 99);
		b = board.bound_table[$urandom_range(0, m - 1)];
		if (r < 35)
			return b;
		if (r < 45)
			return b + 1;
		if (r < 55)
			return b - 1;
		if (r < 62)
			return Q_MIN;
		if (r < 69)
			return Q_MAX;
		return $urandom();
	endfunction

	task automatic send_query(logic signed [VALUE_W-1:0] x);
		send_beat(OP_QUERY, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), x);
	endtask

	// one random phase: set the count, fill the table, then mostly queries
	task automatic run_phase(int p);
		logic [COUNT_W-1:0] cfg;
		int                 m;
		int                 nq;
		int                 r;
		r = $urandom_range(0, 99);
		if (p == 2)
			cfg = 11'd1024;
		else if (p == 4)
			cfg = 11'd2047;
		else if (p == 6)
			cfg = 11'd1025;
		else if (p % 9 == 7)
			cfg = COUNT_W'($urandom_range(100, 1023));
		else if (r < 10)
			cfg = '0;
		else if (r < 20)
			cfg = 11'd1;
		else
			cfg = COUNT_W'($urandom_range(2, 48));
		write_count(cfg);
		m = board.active_segments();

		if (p % 5 == 3 && m <= 64) begin
			for (int i = 0; i < m; i++)
				send_beat(OP_LOAD, INDEX_W'(i), $urandom());
		end else begin
			load_ascending(m, m <= 64);
		end
		// bounds outside the active range must not disturb the search
		if (m < TABLE_DEPTH)
			repeat (2) send_beat(OP_LOAD, INDEX_W'($urandom_range(m, TABLE_DEPTH - 1)),
				$urandom());

		if (p == 1)
			hold_req = 1'b1;
		nq = (m > 64) ? 60 : $urandom_range(10, 40);
		for (int q = 0; q < nq; q++) begin
			if (p == 5 && q == nq / 2)
				wait_drained();
			if ($urandom_range(0, 99) < 4)
				send_beat(OP_LOAD, INDEX_W'($urandom_range(0, m - 1)), $urandom());
			else
				send_query(pick_query(m));
		end
	endtask

	initial begin
		int p;
		board       = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_LOAD;
		entry_index = '0;
		value       = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single segment after reset: every query lands in segment 0
		send_beat(OP_LOAD, '0, Q_MIN);
		send_query(Q_MIN);
		send_query(Q_MAX);
		send_beat(OP_LOAD, '1, Q_MAX);
		// a zero count behaves as one
		write_count('0);
		send_query($urandom());
		// two segments spanning the full range
		write_count(11'd2);
		send_beat(OP_LOAD, 10'd1, Q_MAX);
		send_query(Q_MIN);
		send_query(Q_MAX);
		send_query(32'sd0);
		send_query(-32'sd1);
		// four segments: exact bounds, neighbours and the equality overrides
		write_count(11'd4);
		send_beat(OP_LOAD, 10'd1, -32'sd65536);
		send_beat(OP_LOAD, 10'd2, 32'sd65536);
		send_beat(OP_LOAD, 10'd3, Q_MAX);
		send_query(-32'sd65537);
		send_query(-32'sd65536);
		send_query(32'sd65535);
		send_query(32'sd65536);
		send_query(Q_MAX - 1);
		send_query(Q_MAX);
		// unsorted table
		write_count(11'd3);
		send_beat(OP_LOAD, 10'd1, Q_MAX);
		send_query(32'sd0);
		send_query(Q_MIN + 1);

		p = 0;
		while (items_sent < ITEM_TARGET) begin
			run_phase(p);
			p++;
		end

		// drain and let the pipeline settle
		wait_drained();
		board.finish_check();
		$display("Run covered %0d loads and %0d queries over %0d count settings;",
			board.loads, board.queries, count_writes);
		$display("%0d results checked, %0d failures.", board.checked, board.failures);
		if (board.failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/bsl_pkg.sv
rtl/breakpoint_segment_locate.sv
test/segment_check_pkg.sv
test/breakpoint_segment_locate_test.sv
